// File: sv/tts_pkg.sv
package tts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_RESULTS = 9;
  localparam int NREL = MAX_RESULTS - 1;

  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_TICK     = 3'd1;
  localparam logic [2:0] CMD_DISPATCH = 3'd2;
  localparam logic [2:0] CMD_SUSPEND  = 3'd3;
  localparam logic [2:0] CMD_RESUME   = 3'd4;
  localparam logic [2:0] CMD_DELETE   = 3'd5;

  localparam logic [2:0] RS_DORMANT      = 3'd0;
  localparam logic [2:0] RS_READY        = 3'd1;
  localparam logic [2:0] RS_READY_TO_RUN = 3'd2;
  localparam logic [2:0] RS_SUSPENDED    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_POS  = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  task_position;
    logic [15:0] release_delay;
    logic [15:0] repeat_period;
    logic        cooperative;
    logic [7:0]  task_tag;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] released_tag;
    logic [1:0] status;
    logic [3:0] task_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] period;
    logic        coop;
    logic [7:0]  tag;
    logic [2:0]  run;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: sv/tts_cell.sv
module tts_cell (
  input  logic                clk,
  input  tts_pkg::cell_ctrl_t ctrl,
  input  tts_pkg::entry_t     wr_data,
  input  tts_pkg::entry_t     next_in,
  output tts_pkg::entry_t     ent
);

  tts_pkg::entry_t ent_r;
  tts_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.shift) begin
      ent_nxt = next_in;
    end else if (ctrl.wr) begin
      ent_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// File: sv/tick_task_release_scheduler.sv
// channel | ports                        | transfer
// input   | start, busy, in_data         | start high and busy low at the clock edge
// result  | out_valid, out_data          | out_valid high for one cycle, always taken
//
// add, suspend, resume, delete and unknown commands go from idle straight to the completion item.
// tick and dispatch walk the cell row one position per cycle, except that a removal keeps
// the position; they then close the walk and emit each release item and the completion,
// each registered before it is shown on the ports.
// release items follow the walk so they carry the final task count.
// synchronous active-low reset empties the table; the receiver cannot stall.
module tick_task_release_scheduler #(
  parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tts_pkg::in_item_t  in_data,
  output logic               out_valid,
  output tts_pkg::out_item_t out_data
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int PW = CW + 3;
  localparam int RW = $clog2(tts_pkg::NREL + 1);
  localparam int BW = (tts_pkg::NREL > 1) ? $clog2(tts_pkg::NREL) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [RW-1:0] nrel_r, nrel_nxt;
  logic [RW-1:0] rd_r, rd_nxt;
  logic [7:0]    relbuf_r [tts_pkg::NREL];
  logic          out_valid_r, out_valid_nxt;
  tts_pkg::out_item_t out_r, out_nxt;

  tts_pkg::entry_t    ent [MAX_TASKS];
  tts_pkg::cell_ctrl_t ctrl [MAX_TASKS];
  tts_pkg::entry_t    wr_data, cur;
  logic               wr_en, rm_en, rel_en;
  logic [AW-1:0]      wr_idx, rm_idx, ptr_idx, pos_idx;
  logic               pos_bad;

  assign ptr_idx = AW'(ptr_r);
  assign pos_idx = AW'(in_data.task_position);
  assign cur     = ent[ptr_idx];
  assign pos_bad = PW'(in_data.task_position) >= PW'(count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    nrel_nxt      = nrel_r;
    rd_nxt        = rd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    rm_en         = 1'b0;
    rel_en        = 1'b0;
    wr_idx        = ptr_idx;
    rm_idx        = ptr_idx;
    wr_data       = cur;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_data.command;
          status_nxt = tts_pkg::ST_OK;
          nrel_nxt   = '0;
          rd_nxt     = '0;
          ptr_nxt    = '0;
          state_nxt  = S_EMIT;
          case (in_data.command)
            tts_pkg::CMD_ADD: begin
              if (PW'(count_r) >= PW'(MAX_TASKS)) begin
                status_nxt = tts_pkg::ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_idx         = AW'(count_r);
                wr_data.delay  = in_data.release_delay;
                wr_data.period = in_data.repeat_period;
                wr_data.coop   = in_data.cooperative;
                wr_data.tag    = in_data.task_tag;
                wr_data.run    = tts_pkg::RS_DORMANT;
                count_nxt      = count_r + 1'b1;
              end
            end
            tts_pkg::CMD_TICK, tts_pkg::CMD_DISPATCH: begin
              state_nxt = S_WALK;
            end
            tts_pkg::CMD_SUSPEND, tts_pkg::CMD_RESUME, tts_pkg::CMD_DELETE: begin
              if (pos_bad) begin
                status_nxt = tts_pkg::ST_BAD_POS;
              end else if (in_data.command == tts_pkg::CMD_DELETE) begin
                rm_en     = 1'b1;
                rm_idx    = pos_idx;
                count_nxt = count_r - 1'b1;
              end else begin
                wr_en       = 1'b1;
                wr_idx      = pos_idx;
                wr_data     = ent[pos_idx];
                wr_data.run = (in_data.command == tts_pkg::CMD_SUSPEND) ?
                              tts_pkg::RS_SUSPENDED : tts_pkg::RS_READY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (ptr_r >= count_r) begin
          state_nxt = S_EMIT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          if (cmd_r == tts_pkg::CMD_TICK) begin
            wr_en = 1'b1;
            if (cur.delay != 16'd0) begin
              wr_data.delay = cur.delay - 16'd1;
            end else begin
              if (cur.coop) begin
                wr_data.run = tts_pkg::RS_READY_TO_RUN;
              end else begin
                rel_en      = 1'b1;
                wr_data.run = tts_pkg::RS_READY;
              end
              if (cur.period != 16'd0) begin
                wr_data.delay = cur.period;
              end else if (!cur.coop) begin
                wr_en     = 1'b0;
                rm_en     = 1'b1;
                ptr_nxt   = ptr_r;
                count_nxt = count_r - 1'b1;
              end
            end
          end else if (cur.run == tts_pkg::RS_READY_TO_RUN) begin
            rel_en      = 1'b1;
            wr_en       = 1'b1;
            wr_data.run = tts_pkg::RS_READY;
            if (cur.period == 16'd0) begin
              wr_en     = 1'b0;
              rm_en     = 1'b1;
              ptr_nxt   = ptr_r;
              count_nxt = count_r - 1'b1;
            end
          end
          if (rel_en && (nrel_r < RW'(tts_pkg::NREL))) begin
            nrel_nxt = nrel_r + 1'b1;
          end
        end
      end
      S_EMIT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.task_count  = 4'(count_r);
        if (rd_r < nrel_r) begin
          out_nxt.kind         = 1'b1;
          out_nxt.released_tag = relbuf_r[BW'(rd_r)];
          out_nxt.status       = tts_pkg::ST_OK;
          out_nxt.last         = 1'b0;
          rd_nxt               = rd_r + 1'b1;
        end else begin
          out_nxt.kind         = 1'b0;
          out_nxt.released_tag = 8'd0;
          out_nxt.status       = status_r;
          out_nxt.last         = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  genvar k;
  generate
    for (k = 0; k < MAX_TASKS; k++) begin : g_cell
      assign ctrl[k].wr    = wr_en && (wr_idx == AW'(k));
      assign ctrl[k].shift = rm_en && (rm_idx <= AW'(k));
      tts_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl[k]),
        .wr_data (wr_data),
        .next_in (ent[(k + 1 < MAX_TASKS) ? k + 1 : k]),
        .ent     (ent[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r    <= ptr_nxt;
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    nrel_r   <= nrel_nxt;
    rd_r     <= rd_nxt;
    out_r    <= out_nxt;
    if (rel_en && (nrel_r < RW'(tts_pkg::NREL))) begin
      relbuf_r[BW'(nrel_r)] <= cur.tag;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("completion while busy");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(count_r) <= PW'(MAX_TASKS))
    else $error("task count above table size");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");
  a_rel_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind |-> !out_data.last && out_data.status == tts_pkg::ST_OK)
    else $error("malformed release item");

endmodule
